### rtl/tape_pulse_encoder_assert.svh
// Assertion macros shared by the tape pulse encoder checkers.
// Depends on nothing; include by bare file name.
`ifndef TAPE_PULSE_ENCODER_ASSERT_SVH
`define TAPE_PULSE_ENCODER_ASSERT_SVH

// clocked property, disabled while reset is asserted
`define TPE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tape_pulse_encoder assertion failed");

// clocked property that also holds during reset
`define TPE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("tape_pulse_encoder assertion failed");

`endif

### rtl/tpe_pkg.sv
// Shared types and constants of the tape pulse encoder.
// Depends on nothing.
package tpe_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_HALF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PILOT_CYC   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HALF   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HALF    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_LEN   = 3'd6;

    localparam logic [7:0]  RST_PILOT_HALF  = 8'd25;
    localparam logic [15:0] RST_PILOT_CYC   = 16'd3528;
    localparam logic [7:0]  RST_SYNC_FIRST  = 8'd7;
    localparam logic [7:0]  RST_SYNC_SECOND = 8'd8;
    localparam logic [7:0]  RST_ZERO_HALF   = 8'd9;
    localparam logic [7:0]  RST_ONE_HALF    = 8'd19;
    localparam logic [21:0] RST_PAUSE_LEN   = 22'd220500;

    localparam logic [2:0] RUN_PILOT = 3'd0;
    localparam logic [2:0] RUN_SYNC1 = 3'd1;
    localparam logic [2:0] RUN_SYNC2 = 3'd2;
    localparam logic [2:0] RUN_ZERO  = 3'd3;
    localparam logic [2:0] RUN_ONE   = 3'd4;
    localparam logic [2:0] RUN_PAUSE = 3'd5;

    localparam logic [1:0] JOB_START  = 2'd0;
    localparam logic [1:0] JOB_BYTE   = 2'd1;
    localparam logic [1:0] JOB_ORPHAN = 2'd2;

    localparam logic CMD_START = 1'b0;

    typedef struct packed {
        logic [7:0]  pilot_half;
        logic [15:0] pilot_cycles;
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  zero_half;
        logic [7:0]  one_half;
        logic [21:0] pause_len;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       pause;
    } t_job;

endpackage

### rtl/tpe_front.sv
// Front end: accepts requests, tracks the open block and classifies each request.
// Depends on tpe_pkg.
module tpe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_command,
    input  logic [15:0]   i_block_length,
    input  logic [7:0]    i_data_byte,
    input  logic          i_full,
    output logic          o_push,
    output tpe_pkg::t_job o_job
);
    import tpe_pkg::*;

    logic        r_open, n_open;
    logic [15:0] r_remaining, n_remaining;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        n_open         = r_open;
        n_remaining    = r_remaining;
        o_job.data     = i_data_byte;
        o_job.pause    = 1'b0;
        if (i_command == CMD_START) begin
            o_job.kind  = JOB_START;
            o_job.pause = (i_block_length == 16'd0);
            n_open      = (i_block_length != 16'd0);
            n_remaining = i_block_length;
        end else if (!r_open) begin
            o_job.kind = JOB_ORPHAN;
        end else begin
            o_job.kind  = JOB_BYTE;
            n_remaining = r_remaining - 16'd1;
            if (r_remaining == 16'd1) begin
                o_job.pause = 1'b1;
                n_open      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= 1'b0;
            r_remaining <= 16'd0;
        end else if (o_push) begin
            r_open      <= n_open;
            r_remaining <= n_remaining;
        end
    end

endmodule

### rtl/tpe_queue.sv
// Short job queue between front end and run sequencer.
// Depends on tpe_pkg.
module tpe_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tpe_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_head_valid,
    output tpe_pkg::t_job o_head,
    input  logic          i_pop
);
    import tpe_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             push_en, pop_en;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign push_en      = i_push && !o_full;
    assign pop_en       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push_en) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (pop_en) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (push_en && !pop_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_en && !push_en) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

### rtl/tpe_back.sv
// Back end: expands queued jobs into runs, one per cycle unless stalled, then
// multiplies and accumulates the saturating sample total. Depends on tpe_pkg.
module tpe_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  tpe_pkg::t_cfg i_cfg,
    input  logic          i_head_valid,
    input  tpe_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [2:0]    o_run_kind,
    output logic          o_start_level,
    output logic [21:0]   o_half_period_samples,
    output logic [16:0]   o_repeat_count,
    output logic [31:0]   o_total_samples,
    output logic          o_error,
    output logic          o_last
);
    import tpe_pkg::*;

    logic [3:0]  r_step;
    logic        r_level;
    logic [2:0]  run_kind;
    logic [21:0] run_half;
    logic [16:0] run_reps;
    logic        run_err, run_last, fire, en_p, en_out;

    logic        r_pv, r_p_level, r_p_err, r_p_last;
    logic [2:0]  r_p_kind;
    logic [21:0] r_p_half;
    logic [16:0] r_p_reps;
    logic [38:0] r_p_prod;

    logic        r_ov, r_o_level, r_o_err, r_o_last;
    logic [2:0]  r_o_kind;
    logic [21:0] r_o_half;
    logic [16:0] r_o_reps;
    logic [31:0] r_total;
    logic [39:0] sum;

    assign en_out = !r_ov || i_out_ready;
    assign en_p   = !r_pv || en_out;
    assign fire   = i_head_valid && en_p;
    assign o_pop  = fire && run_last;

    always_comb begin
        run_kind = RUN_PILOT;
        run_half = '0;
        run_reps = '0;
        run_err  = 1'b0;
        run_last = 1'b0;
        unique case (i_head.kind)
            JOB_START: begin
                unique case (r_step)
                    4'd0: begin
                        run_kind = RUN_PILOT;
                        run_half = {14'd0, i_cfg.pilot_half};
                        run_reps = {i_cfg.pilot_cycles, 1'b0};
                    end
                    4'd1: begin
                        run_kind = RUN_SYNC1;
                        run_half = {14'd0, i_cfg.sync_first};
                        run_reps = 17'd1;
                    end
                    4'd2: begin
                        run_kind = RUN_SYNC2;
                        run_half = {14'd0, i_cfg.sync_second};
                        run_reps = 17'd1;
                        run_last = !i_head.pause;
                    end
                    default: begin
                        run_kind = RUN_PAUSE;
                        run_half = i_cfg.pause_len;
                        run_reps = 17'd1;
                        run_last = 1'b1;
                    end
                endcase
            end
            JOB_BYTE: begin
                if (r_step[3]) begin
                    run_kind = RUN_PAUSE;
                    run_half = i_cfg.pause_len;
                    run_reps = 17'd1;
                    run_last = 1'b1;
                end else begin
                    if (i_head.data[3'd7 - r_step[2:0]]) begin
                        run_kind = RUN_ONE;
                        run_half = {14'd0, i_cfg.one_half};
                    end else begin
                        run_kind = RUN_ZERO;
                        run_half = {14'd0, i_cfg.zero_half};
                    end
                    run_reps = 17'd2;
                    run_last = (r_step[2:0] == 3'd7) && !i_head.pause;
                end
            end
            default: begin
                run_err  = 1'b1;
                run_last = 1'b1;
            end
        endcase
    end

    assign sum = {8'd0, r_total} + {1'b0, r_p_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_level <= 1'b0;
            r_pv    <= 1'b0;
            r_ov    <= 1'b0;
            r_total <= '0;
        end else begin
            if (fire) begin
                r_step <= run_last ? 4'd0 : r_step + 4'd1;
                if (run_reps[0]) begin
                    r_level <= !r_level;
                end
            end
            if (en_p) begin
                r_pv <= fire;
            end
            if (en_out) begin
                r_ov <= r_pv;
                if (r_pv) begin
                    r_total <= (sum[39:32] != 8'd0) ? 32'hFFFF_FFFF : sum[31:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_p_kind  <= run_kind;
            r_p_level <= r_level;
            r_p_half  <= run_half;
            r_p_reps  <= run_reps;
            r_p_err   <= run_err;
            r_p_last  <= run_last;
            r_p_prod  <= run_half * run_reps;
        end
        if (en_out && r_pv) begin
            r_o_kind  <= r_p_kind;
            r_o_level <= r_p_level;
            r_o_half  <= r_p_half;
            r_o_reps  <= r_p_reps;
            r_o_err   <= r_p_err;
            r_o_last  <= r_p_last;
        end
    end

    assign o_out_valid           = r_ov;
    assign o_run_kind            = r_o_kind;
    assign o_start_level         = r_o_level;
    assign o_half_period_samples = r_o_half;
    assign o_repeat_count        = r_o_reps;
    assign o_total_samples       = r_total;
    assign o_error               = r_o_err;
    assign o_last                = r_o_last;

endmodule

### rtl/tape_pulse_encoder.sv
// Top level of the tape pulse encoder: configuration registers, front end,
// job queue and run back end. Depends on tpe_pkg, tpe_front, tpe_queue, tpe_back.
//
//   channel   handshake                     payload
//   input     i_in_valid / o_in_ready       i_command, i_block_length, i_data_byte
//   result    o_out_valid / i_out_ready     o_run_kind .. o_last
//   config    i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// The back end emits one run per cycle unless its result stalls: a data
// byte gives 8 runs (9 when it closes its block), a block start 3 or 4, an orphan
// byte 1. The first run of a request becomes valid after the queue write, the
// multiply stage and the accumulate stage have each registered it.
// A stalled result holds the back end; the queue keeps accepting until full.
// Synchronous reset clears block state, level and total and restores registers.
module tape_pulse_encoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_block_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_run_kind,
    output logic        o_start_level,
    output logic [21:0] o_half_period_samples,
    output logic [16:0] o_repeat_count,
    output logic [31:0] o_total_samples,
    output logic        o_error,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [tpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tpe_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import tpe_pkg::*;

    t_cfg r_cfg;
    t_job front_job, head_job;
    logic full, push, head_valid, pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pilot_half   <= RST_PILOT_HALF;
            r_cfg.pilot_cycles <= RST_PILOT_CYC;
            r_cfg.sync_first   <= RST_SYNC_FIRST;
            r_cfg.sync_second  <= RST_SYNC_SECOND;
            r_cfg.zero_half    <= RST_ZERO_HALF;
            r_cfg.one_half     <= RST_ONE_HALF;
            r_cfg.pause_len    <= RST_PAUSE_LEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PILOT_HALF:  r_cfg.pilot_half   <= i_cfg_data[7:0];
                CFG_PILOT_CYC:   r_cfg.pilot_cycles <= i_cfg_data[15:0];
                CFG_SYNC_FIRST:  r_cfg.sync_first   <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second  <= i_cfg_data[7:0];
                CFG_ZERO_HALF:   r_cfg.zero_half    <= i_cfg_data[7:0];
                CFG_ONE_HALF:    r_cfg.one_half     <= i_cfg_data[7:0];
                CFG_PAUSE_LEN:   r_cfg.pause_len    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tpe_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_block_length (i_block_length),
        .i_data_byte    (i_data_byte),
        .i_full         (full),
        .o_push         (push),
        .o_job          (front_job)
    );

    tpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (front_job),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head_job),
        .i_pop        (pop)
    );

    tpe_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg                 (r_cfg),
        .i_head_valid          (head_valid),
        .i_head                (head_job),
        .o_pop                 (pop),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_run_kind            (o_run_kind),
        .o_start_level         (o_start_level),
        .o_half_period_samples (o_half_period_samples),
        .o_repeat_count        (o_repeat_count),
        .o_total_samples       (o_total_samples),
        .o_error               (o_error),
        .o_last                (o_last)
    );

endmodule

### rtl/tape_pulse_encoder_props.sv
// Port-level checks of the tape pulse encoder, bound to the top level.
// Depends on tpe_pkg and tape_pulse_encoder_assert.svh.
`include "tape_pulse_encoder_assert.svh"

module tape_pulse_encoder_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_run_kind,
    input logic [21:0] o_half_period_samples,
    input logic [16:0] o_repeat_count,
    input logic [31:0] o_total_samples,
    input logic        o_error,
    input logic        o_last
);
    import tpe_pkg::*;

    `TPE_ASSERT(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready |=> o_out_valid))
    `TPE_ASSERT(a_error_shape, i_clk, i_rst_n, (o_out_valid && o_error |-> o_repeat_count == 17'd0 && o_half_period_samples == 22'd0 && o_last))
    `TPE_ASSERT(a_total_grows, i_clk, i_rst_n, (o_out_valid && i_out_ready |=> o_total_samples >= $past(o_total_samples)))
    `TPE_ASSERT(a_pilot_even, i_clk, i_rst_n, (o_out_valid && !o_error && o_run_kind == RUN_PILOT |-> !o_repeat_count[0]))

endmodule

bind tape_pulse_encoder tape_pulse_encoder_props u_props (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .o_out_valid           (o_out_valid),
    .i_out_ready           (i_out_ready),
    .o_run_kind            (o_run_kind),
    .o_half_period_samples (o_half_period_samples),
    .o_repeat_count        (o_repeat_count),
    .o_total_samples       (o_total_samples),
    .o_error               (o_error),
    .o_last                (o_last)
);

### tb/sv/tb_top.sv
// Self-checking testbench of tape_pulse_encoder: requests are driven from a queue,
// expected runs come from a predictor in this file and are checked in order.
// Depends on tpe_pkg and tape_pulse_encoder.
module tb_top;
    import tpe_pkg::*;

    localparam logic                 CMD_BYTE       = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 3'd7;
    localparam int                   DRAIN_CYCLES   = 8;
    localparam int                   WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic        cmd;
        logic [15:0] len;
        logic [7:0]  data;
    } t_request;

    typedef struct packed {
        logic [2:0]  kind;
        logic        level;
        logic [21:0] half;
        logic [16:0] reps;
        logic [31:0] total;
        logic        err;
        logic        last;
    } t_run;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic                  i_command = 1'b0;
    logic [15:0]           i_block_length = '0;
    logic [7:0]            i_data_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [2:0]            o_run_kind;
    logic                  o_start_level;
    logic [21:0]           o_half_period_samples;
    logic [16:0]           o_repeat_count;
    logic [31:0]           o_total_samples;
    logic                  o_error;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    t_request pending_requests[$];
    t_run     runs_due[$];

    t_cfg        regs_now;
    logic        tape_level = 1'b0;
    logic [15:0] bytes_left = '0;
    logic        block_open = 1'b0;
    logic [31:0] sample_sum = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int stall_cycles = 0;

    tape_pulse_encoder dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_command             (i_command),
        .i_block_length        (i_block_length),
        .i_data_byte           (i_data_byte),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_run_kind            (o_run_kind),
        .o_start_level         (o_start_level),
        .o_half_period_samples (o_half_period_samples),
        .o_repeat_count        (o_repeat_count),
        .o_total_samples       (o_total_samples),
        .o_error               (o_error),
        .o_last                (o_last),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic emit_run(input logic [2:0] kind, input logic [21:0] half,
                            input logic [16:0] reps);
        t_run        r;
        logic [63:0] sum;
        sum = 64'(sample_sum) + 64'(half) * 64'(reps);
        if (sum > 64'hFFFF_FFFF) begin
            sum = 64'hFFFF_FFFF;
        end
        r.kind  = kind;
        r.level = tape_level;
        r.half  = half;
        r.reps  = reps;
        r.total = sum[31:0];
        r.err   = 1'b0;
        r.last  = 1'b0;
        sample_sum = sum[31:0];
        runs_due.push_back(r);
        if (reps[0]) begin
            tape_level = ~tape_level;
        end
    endtask

    task automatic predict_runs(input t_request req);
        t_run r;
        if (req.cmd == CMD_START) begin
            emit_run(RUN_PILOT, 22'(regs_now.pilot_half), {regs_now.pilot_cycles, 1'b0});
            emit_run(RUN_SYNC1, 22'(regs_now.sync_first), 17'd1);
            emit_run(RUN_SYNC2, 22'(regs_now.sync_second), 17'd1);
            if (req.len == 16'd0) begin
                emit_run(RUN_PAUSE, regs_now.pause_len, 17'd1);
                block_open = 1'b0;
                bytes_left = '0;
            end else begin
                block_open = 1'b1;
                bytes_left = req.len;
            end
        end else if (!block_open) begin
            r.kind  = RUN_PILOT;
            r.level = tape_level;
            r.half  = '0;
            r.reps  = '0;
            r.total = sample_sum;
            r.err   = 1'b1;
            r.last  = 1'b0;
            runs_due.push_back(r);
        end else begin
            for (int i = 7; i >= 0; i--) begin
                if (req.data[i]) begin
                    emit_run(RUN_ONE, 22'(regs_now.one_half), 17'd2);
                end else begin
                    emit_run(RUN_ZERO, 22'(regs_now.zero_half), 17'd2);
                end
            end
            bytes_left = bytes_left - 16'd1;
            if (bytes_left == 16'd0) begin
                emit_run(RUN_PAUSE, regs_now.pause_len, 17'd1);
                block_open = 1'b0;
            end
        end
        r = runs_due.pop_back();
        r.last = 1'b1;
        runs_due.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_request req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                req.cmd  = i_command;
                req.len  = i_block_length;
                req.data = i_data_byte;
                predict_runs(req);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req = pending_requests.pop_front();
                    i_in_valid     <= 1'b1;
                    i_command      <= req.cmd;
                    i_block_length <= req.len;
                    i_data_byte    <= req.data;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_runs
        t_run want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (runs_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected run, expected none, actual kind %0d total %0d",
                             $time, o_run_kind, o_total_samples);
                end else begin
                    want = runs_due.pop_front();
                    check_field("run_kind", want.kind, o_run_kind);
                    check_field("start_level", want.level, o_start_level);
                    check_field("half_period_samples", want.half, o_half_period_samples);
                    check_field("repeat_count", want.reps, o_repeat_count);
                    check_field("total_samples", want.total, o_total_samples);
                    check_field("error", want.err, o_error);
                    check_field("last", want.last, o_last);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_start(input logic [15:0] len);
        t_request req;
        req.cmd  = CMD_START;
        req.len  = len;
        req.data = 8'($urandom_range(255));
        pending_requests.push_back(req);
    endtask

    task automatic push_byte(input logic [7:0] data);
        t_request req;
        req.cmd  = CMD_BYTE;
        req.len  = 16'($urandom_range(65535));
        req.data = data;
        pending_requests.push_back(req);
    endtask

    task automatic queue_traffic(input int count, input int empty_pct);
        int made;
        int pick;
        int nbytes;
        int keep;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < empty_pct) begin
                push_start(16'd0);
                made++;
            end else if (pick < empty_pct + 8) begin
                push_byte(8'($urandom_range(255)));
                made++;
            end else if (pick < empty_pct + 14) begin
                // open a long block and abandon it with the next start
                push_start(16'($urandom_range(65535)));
                nbytes = $urandom_range(3);
                repeat (nbytes) push_byte(8'($urandom_range(255)));
                made += 1 + nbytes;
            end else begin
                nbytes = $urandom_range(1, 4);
                keep = ($urandom_range(9) == 0) ? $urandom_range(nbytes - 1) : nbytes;
                push_start(16'(nbytes));
                repeat (keep) push_byte(8'($urandom_range(255)));
                made += 1 + keep;
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_requests.size() != 0 || i_in_valid || runs_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PILOT_HALF:  regs_now.pilot_half   = value[7:0];
            CFG_PILOT_CYC:   regs_now.pilot_cycles = value[15:0];
            CFG_SYNC_FIRST:  regs_now.sync_first   = value[7:0];
            CFG_SYNC_SECOND: regs_now.sync_second  = value[7:0];
            CFG_ZERO_HALF:   regs_now.zero_half    = value[7:0];
            CFG_ONE_HALF:    regs_now.one_half     = value[7:0];
            CFG_PAUSE_LEN:   regs_now.pause_len    = value;
            default: ;
        endcase
    endtask

    task automatic load_profile(input t_cfg p);
        write_reg(CFG_PILOT_HALF, 22'(p.pilot_half));
        write_reg(CFG_PILOT_CYC, 22'(p.pilot_cycles));
        write_reg(CFG_SYNC_FIRST, 22'(p.sync_first));
        write_reg(CFG_SYNC_SECOND, 22'(p.sync_second));
        write_reg(CFG_ZERO_HALF, 22'(p.zero_half));
        write_reg(CFG_ONE_HALF, 22'(p.one_half));
        write_reg(CFG_PAUSE_LEN, p.pause_len);
    endtask

    function automatic t_cfg random_profile();
        t_cfg p;
        p.pilot_half   = 8'($urandom_range(1, 255));
        p.pilot_cycles = 16'($urandom_range(1, 65535));
        p.sync_first   = 8'($urandom_range(1, 255));
        p.sync_second  = 8'($urandom_range(1, 255));
        p.zero_half    = 8'($urandom_range(1, 255));
        p.one_half     = 8'($urandom_range(1, 255));
        p.pause_len    = 22'($urandom_range(0, 4194303));
        return p;
    endfunction

    initial begin : run_phases
        t_cfg p;
        regs_now.pilot_half   = RST_PILOT_HALF;
        regs_now.pilot_cycles = RST_PILOT_CYC;
        regs_now.sync_first   = RST_SYNC_FIRST;
        regs_now.sync_second  = RST_SYNC_SECOND;
        regs_now.zero_half    = RST_ZERO_HALF;
        regs_now.one_half     = RST_ONE_HALF;
        regs_now.pause_len    = RST_PAUSE_LEN;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 56;
        // orphan bytes, empty block, closing bytes, restarts while open
        push_byte(8'h00);
        push_byte(8'hFF);
        push_start(16'd0);
        push_start(16'd1);
        push_byte(8'h00);
        push_start(16'd2);
        push_byte(8'hFF);
        push_byte(8'hA5);
        push_start(16'd3);
        push_byte(8'h5A);
        push_start(16'hFFFF);
        push_byte(8'h01);
        push_byte(8'h80);
        push_start(16'd1);
        push_byte(8'hC3);
        push_byte(8'h7E);
        push_start(16'h8000);
        push_byte(8'h3C);
        push_start(16'd0);
        wait_drained();

        p.pilot_half   = 8'd1;
        p.pilot_cycles = 16'd1;
        p.sync_first   = 8'd1;
        p.sync_second  = 8'd1;
        p.zero_half    = 8'd1;
        p.one_half     = 8'd1;
        p.pause_len    = 22'd0;
        load_profile(p);
        queue_traffic(40, 10);
        wait_drained();

        send_idle_pct = 56;
        recv_idle_pct = 29;
        p = '0;
        load_profile(p);
        write_reg(CFG_UNUSED, 22'($urandom_range(0, 4194303)));
        queue_traffic(25, 15);
        wait_drained();

        load_profile(random_profile());
        queue_traffic(40, 10);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_profile(random_profile());
        queue_traffic(20, 10);
        wait_drained();
        queue_traffic(20, 10);
        wait_drained();

        // run the total into saturation
        p.pilot_half   = 8'd255;
        p.pilot_cycles = 16'hFFFF;
        p.sync_first   = 8'd255;
        p.sync_second  = 8'd255;
        p.zero_half    = 8'd255;
        p.one_half     = 8'd255;
        p.pause_len    = 22'h3F_FFFF;
        load_profile(p);
        queue_traffic(150, 75);
        wait_drained();

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
